// File: src/spiral_order_matrix_reader_top_defines.svh
`ifndef SPIRAL_ORDER_MATRIX_READER_TOP_DEFINES_SVH
`define SPIRAL_ORDER_MATRIX_READER_TOP_DEFINES_SVH

// check that cond holds in the same cycle as trig
`define SOMR_ASSERT_SAME(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error(msg);

// check that cond holds in the cycle after trig
`define SOMR_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// File: src/somr_pkg.sv
package somr_pkg;

    localparam int SIZE_W     = 5;
    localparam int IDX_W      = 4;
    localparam int VALUE_W    = 32;
    localparam int CNT_W      = 2 * SIZE_W;
    localparam int CFG_ADDR_W = 1;
    localparam int RESET_SIZE = 16;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EMIT  = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] REG_ROW_COUNT    = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_COLUMN_COUNT = CFG_ADDR_W'(1);

endpackage

// File: src/spiral_order_matrix_reader_top.sv
// Channel   Dir  Handshake               Payload
// s         in   i_s_tvalid/o_s_tready   i_s_tuser cmd; i_s_tdata row, column, value
// m         out  o_m_tvalid/i_m_tready   o_m_tdata value, row, column; o_m_tlast last
// cfg       in   i_cfg_we                i_cfg_index, i_cfg_data
//
// One beat per cycle on the slave side while o_s_tready is high; an emit beat
// goes through the element RAM read register and the output register to the master.
// Reset (synchronous, active low) sets both sizes to 16 and the walk to the origin.
// A master-side stall fills the output register, then the read stage, then
// drops o_s_tready; nothing is lost.

`include "spiral_order_matrix_reader_top_defines.svh"

module spiral_order_matrix_reader_top #(
    parameter int MAX_ROWS    = 16,
    parameter int MAX_COLUMNS = 16,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // [3:0] row_index, [7:4] column_index, [39:8] value
    input  logic [39:0]                          i_s_tdata,
    // [0] cmd
    input  logic                                 i_s_tuser,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // [31:0] out_value, [35:32] out_row, [39:36] out_column
    output logic [39:0]                          o_m_tdata,
    output logic                                 o_m_tlast,
    input  logic                                 i_cfg_we,
    input  logic [somr_pkg::CFG_ADDR_W-1:0]      i_cfg_index,
    input  logic [somr_pkg::SIZE_W-1:0]          i_cfg_data
);

    localparam int SW      = somr_pkg::SIZE_W;
    localparam int IW      = somr_pkg::IDX_W;
    localparam int VW      = somr_pkg::VALUE_W;
    localparam int CW      = somr_pkg::CNT_W;
    localparam int ROW_W   = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W   = MAX_COLUMNS > 1 ? $clog2(MAX_COLUMNS) : 1;
    localparam int DEPTH   = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W  = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int STORE_W = DATA_WIDTH < VW ? DATA_WIDTH : VW;
    localparam int RST_ROWS = MAX_ROWS < somr_pkg::RESET_SIZE ? MAX_ROWS : somr_pkg::RESET_SIZE;
    localparam int RST_COLS = MAX_COLUMNS < somr_pkg::RESET_SIZE ? MAX_COLUMNS
                                                                 : somr_pkg::RESET_SIZE;

    typedef enum logic [1:0] {
        LEG_RIGHT = 2'd0,
        LEG_DOWN  = 2'd1,
        LEG_LEFT  = 2'd2,
        LEG_UP    = 2'd3
    } t_leg;

    function automatic logic [SW-1:0] f_clamp(input logic [SW-1:0] v, input int lim);
        logic [SW-1:0] res;
        res = v;
        if (v == '0) begin
            res = SW'(1);
        end else if (int'(v) > lim) begin
            res = SW'(lim);
        end
        return res;
    endfunction

    logic [SW-1:0] r_row_count, n_row_count;
    logic [SW-1:0] r_column_count, n_column_count;
    logic [SW-1:0] r_ring_left, n_ring_left;
    logic [SW-1:0] r_ring_top, n_ring_top;
    logic [SW-1:0] r_ring_right, n_ring_right;
    logic [SW-1:0] r_ring_bottom, n_ring_bottom;
    logic [SW-1:0] r_walk_row, n_walk_row;
    logic [SW-1:0] r_walk_column, n_walk_column;
    t_leg          r_walk_leg, n_walk_leg;
    logic [CW-1:0] r_emitted, n_emitted;
    logic          r_s1_valid, n_s1_valid;
    logic          r_out_valid, n_out_valid;

    logic [IW-1:0]      r_s1_row;
    logic [IW-1:0]      r_s1_column;
    logic               r_s1_last;
    logic [VW-1:0]      r_out_value;
    logic [IW-1:0]      r_out_row;
    logic [IW-1:0]      r_out_column;
    logic               r_out_last;

    logic               accept;
    logic               is_emit;
    logic               out_ready;
    logic               s1_ready;
    logic               restart;
    logic               is_last;
    logic               wr_in_range;
    logic [SW-1:0]      rows_eff;
    logic [SW-1:0]      cols_eff;
    logic [CW-1:0]      total;
    logic [CW-1:0]      count_inc;
    logic [ROW_W-1:0]   rd_row;
    logic [COL_W-1:0]   rd_col;
    logic [ROW_W-1:0]   wr_row;
    logic [COL_W-1:0]   wr_col;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic [STORE_W-1:0] rd_data;
    logic [IW-1:0]      in_row;
    logic [IW-1:0]      in_column;
    logic [VW-1:0]      in_value;

    assign in_row    = i_s_tdata[IW-1:0];
    assign in_column = i_s_tdata[2*IW-1:IW];
    assign in_value  = i_s_tdata[2*IW+VW-1:2*IW];

    assign out_ready  = !r_out_valid || i_m_tready;
    assign s1_ready   = !r_s1_valid || out_ready;
    assign o_s_tready = s1_ready;
    assign accept     = i_s_tvalid && s1_ready;
    assign is_emit    = i_s_tuser == somr_pkg::CMD_EMIT;

    assign rows_eff  = f_clamp(r_row_count, MAX_ROWS);
    assign cols_eff  = f_clamp(r_column_count, MAX_COLUMNS);
    assign total     = CW'(rows_eff) * CW'(cols_eff);
    assign count_inc = r_emitted + CW'(1);
    assign is_last   = count_inc >= total;

    assign rd_row  = int'(r_walk_row) >= MAX_ROWS ? ROW_W'(MAX_ROWS - 1) : ROW_W'(r_walk_row);
    assign rd_col  = int'(r_walk_column) >= MAX_COLUMNS ? COL_W'(MAX_COLUMNS - 1)
                                                        : COL_W'(r_walk_column);
    assign rd_addr = ADDR_W'(int'(rd_row) * MAX_COLUMNS + int'(rd_col));

    assign wr_in_range = int'(in_row) < MAX_ROWS && int'(in_column) < MAX_COLUMNS;
    assign wr_row      = ROW_W'(in_row);
    assign wr_col      = COL_W'(in_column);
    assign wr_addr     = ADDR_W'(int'(wr_row) * MAX_COLUMNS + int'(wr_col));

    somr_ram #(
        .WIDTH (STORE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (accept && !is_emit && wr_in_range),
        .i_waddr (wr_addr),
        .i_wdata (in_value[STORE_W-1:0]),
        .i_re    (accept && is_emit),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_row_count    = r_row_count;
        n_column_count = r_column_count;
        n_ring_left    = r_ring_left;
        n_ring_top     = r_ring_top;
        n_ring_right   = r_ring_right;
        n_ring_bottom  = r_ring_bottom;
        n_walk_row     = r_walk_row;
        n_walk_column  = r_walk_column;
        n_walk_leg     = r_walk_leg;
        n_emitted      = r_emitted;
        restart        = 1'b0;

        if (i_cfg_we) begin
            case (i_cfg_index)
                somr_pkg::REG_ROW_COUNT: begin
                    n_row_count = i_cfg_data;
                    restart     = 1'b1;
                end
                somr_pkg::REG_COLUMN_COUNT: begin
                    n_column_count = i_cfg_data;
                    restart        = 1'b1;
                end
                default: begin
                end
            endcase
        end

        if (accept && !is_emit) begin
            restart = 1'b1;
        end

        if (accept && is_emit) begin
            n_emitted = count_inc;
            if (is_last) begin
                restart = 1'b1;
            end else begin
                case (r_walk_leg)
                    LEG_RIGHT: begin
                        if (r_walk_column < r_ring_right) begin
                            n_walk_column = r_walk_column + SW'(1);
                        end else begin
                            n_ring_top = r_ring_top + SW'(1);
                            n_walk_leg = LEG_DOWN;
                            n_walk_row = r_walk_row + SW'(1);
                        end
                    end
                    LEG_DOWN: begin
                        if (r_walk_row < r_ring_bottom) begin
                            n_walk_row = r_walk_row + SW'(1);
                        end else begin
                            if (r_ring_right != '0) begin
                                n_ring_right = r_ring_right - SW'(1);
                            end
                            n_walk_leg = LEG_LEFT;
                            if (r_walk_column != '0) begin
                                n_walk_column = r_walk_column - SW'(1);
                            end
                        end
                    end
                    LEG_LEFT: begin
                        if (r_walk_column > r_ring_left) begin
                            n_walk_column = r_walk_column - SW'(1);
                        end else begin
                            if (r_ring_bottom != '0) begin
                                n_ring_bottom = r_ring_bottom - SW'(1);
                            end
                            n_walk_leg = LEG_UP;
                            if (r_walk_row != '0) begin
                                n_walk_row = r_walk_row - SW'(1);
                            end
                        end
                    end
                    default: begin
                        if (r_walk_row > r_ring_top) begin
                            n_walk_row = r_walk_row - SW'(1);
                        end else begin
                            n_ring_left   = r_ring_left + SW'(1);
                            n_walk_leg    = LEG_RIGHT;
                            n_walk_column = r_walk_column + SW'(1);
                        end
                    end
                endcase
            end
        end

        if (restart) begin
            n_ring_left   = '0;
            n_ring_top    = '0;
            n_ring_right  = f_clamp(n_column_count, MAX_COLUMNS) - SW'(1);
            n_ring_bottom = f_clamp(n_row_count, MAX_ROWS) - SW'(1);
            n_walk_row    = '0;
            n_walk_column = '0;
            n_walk_leg    = LEG_RIGHT;
            n_emitted     = '0;
        end

        n_s1_valid  = r_s1_valid;
        n_out_valid = r_out_valid;
        if (out_ready) begin
            n_out_valid = r_s1_valid;
            n_s1_valid  = 1'b0;
        end
        if (accept && is_emit) begin
            n_s1_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= SW'(somr_pkg::RESET_SIZE);
            r_column_count <= SW'(somr_pkg::RESET_SIZE);
            r_ring_left    <= '0;
            r_ring_top     <= '0;
            r_ring_right   <= SW'(RST_COLS - 1);
            r_ring_bottom  <= SW'(RST_ROWS - 1);
            r_walk_row     <= '0;
            r_walk_column  <= '0;
            r_walk_leg     <= LEG_RIGHT;
            r_emitted      <= '0;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_row_count    <= n_row_count;
            r_column_count <= n_column_count;
            r_ring_left    <= n_ring_left;
            r_ring_top     <= n_ring_top;
            r_ring_right   <= n_ring_right;
            r_ring_bottom  <= n_ring_bottom;
            r_walk_row     <= n_walk_row;
            r_walk_column  <= n_walk_column;
            r_walk_leg     <= n_walk_leg;
            r_emitted      <= n_emitted;
            r_s1_valid     <= n_s1_valid;
            r_out_valid    <= n_out_valid;
        end
    end

    // hold payload while stalled
    always_ff @(posedge i_clk) begin
        if (accept && is_emit) begin
            r_s1_row    <= IW'(rd_row);
            r_s1_column <= IW'(rd_col);
            r_s1_last   <= is_last;
        end
        if (out_ready && r_s1_valid) begin
            r_out_value  <= VW'(rd_data);
            r_out_row    <= r_s1_row;
            r_out_column <= r_s1_column;
            r_out_last   <= r_s1_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_column, r_out_row, r_out_value};
    assign o_m_tlast  = r_out_last;

    `SOMR_ASSERT_SAME(a_stall_only_when_full, !o_s_tready, r_s1_valid && r_out_valid,
        "input stalled with a free stage")
    `SOMR_ASSERT_SAME(a_count_below_total, 1'b1, r_emitted < total,
        "emitted count reached pass length")
    `SOMR_ASSERT_NEXT(a_last_restarts, accept && is_emit && is_last,
        r_walk_row == '0 && r_walk_column == '0 && r_emitted == '0,
        "walk not restarted after last element")
    `SOMR_ASSERT_NEXT(a_write_restarts, accept && !is_emit,
        r_emitted == '0 && r_walk_leg == LEG_RIGHT && !$rose(r_s1_valid),
        "write did not restart walk")

endmodule

// File: src/somr_ram.sv
module somr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
